### design/tngs_pkg.sv
// tngs_pkg: shared types, constants and helpers for the take-next-greater set unit
// no dependencies; imported by every module of the block except tngs_ram

package tngs_pkg;

	localparam int VAL_W         = 12;
	localparam int WORD_BITS     = 64;
	localparam int OFF_W         = 6;
	localparam int MAX_VALUE_DEF = 4096;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_TAKE   = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] taken_value;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mem_rd;
		logic hop;
		logic eval_done;
		logic mem_wr;
		logic clear_res;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_take;
		logic in_range;
		logic op_take;
		logic word_hit;
		logic next_any;
	} dp_sts_t;

	function automatic logic [OFF_W-1:0] lowest64(input logic [WORD_BITS-1:0] w);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = OFF_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

### design/tngs_ram.sv
// tngs_ram: generic single-port ram with registered read
// no dependencies

module tngs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

### design/tngs_dp.sv
// tngs_dp: datapath, bitmap words in ram plus a per-word nonzero summary
// depends on tngs_pkg and tngs_ram

module tngs_dp #(
	parameter int MAX_VALUE = tngs_pkg::MAX_VALUE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tngs_pkg::req_t     req,
	input  tngs_pkg::ctl_cmd_t cmd,
	output tngs_pkg::dp_sts_t  sts,
	output tngs_pkg::res_t     result
);

	import tngs_pkg::*;

	// only values below 2**VAL_W can ever be stored
	localparam int MAP_BITS = (MAX_VALUE < (1 << VAL_W)) ? MAX_VALUE : (1 << VAL_W);
	localparam int WORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic                 op_q;
	logic [WIDX_W-1:0]    word_q;
	logic [OFF_W-1:0]     off_q;
	logic [WORDS-1:0]     sum_q;
	logic [WORD_BITS-1:0] wnew_q;
	res_t                 res_q;

	logic [VAL_W:0]       base;
	logic [WORD_BITS-1:0] rdata;
	logic [WORD_BITS-1:0] eff;
	logic [WORD_BITS-1:0] masked;
	logic [OFF_W-1:0]     lsb;
	logic [WORDS-1:0]     higher;
	logic [WIDX_W-1:0]    next_idx;

	// threshold of a take starts one above the given value
	assign base = {1'b0, req.value} + (VAL_W+1)'(req.req_type == REQ_TAKE);

	tngs_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORDS),
		.AW   (WIDX_W)
	) u_map (
		.clk  (clk),
		.we   (cmd.mem_wr),
		.re   (cmd.mem_rd),
		.addr (word_q),
		.wdata(wnew_q),
		.rdata(rdata)
	);

	// a word whose summary bit is clear is empty whatever the ram holds
	assign eff    = sum_q[word_q] ? rdata : '0;
	assign masked = eff & ({WORD_BITS{1'b1}} << off_q);
	assign lsb    = lowest64(masked);
	assign higher = sum_q & (({WORDS{1'b1}} << word_q) << 1);

	always_comb begin
		next_idx = '0;
		for (int i = WORDS - 1; i >= 0; i--) begin
			if (higher[i]) begin
				next_idx = WIDX_W'(i);
			end
		end
	end

	always_comb begin
		sts.in_take  = (req.req_type == REQ_TAKE);
		sts.in_range = (base < (VAL_W+1)'(MAP_BITS)) &&
			((req.req_type == REQ_TAKE) || (req.value != '0));
		sts.op_take  = op_q;
		sts.word_hit = (masked != '0);
		sts.next_any = (higher != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= req.req_type;
			word_q <= WIDX_W'(base >> OFF_W);
			off_q  <= base[OFF_W-1:0];
		end else if (cmd.hop) begin
			word_q <= next_idx;
			off_q  <= '0;
		end
		if (cmd.eval_done) begin
			if (op_q == REQ_TAKE) begin
				wnew_q            <= eff & ~({{(WORD_BITS-1){1'b0}}, 1'b1} << lsb);
				res_q.found       <= 1'b1;
				res_q.taken_value <= VAL_W'({word_q, lsb});
			end else begin
				wnew_q <= eff | ({{(WORD_BITS-1){1'b0}}, 1'b1} << off_q);
			end
		end else if (cmd.clear_res) begin
			res_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.mem_wr) begin
			sum_q[word_q] <= (wnew_q != '0);
		end
	end

	assign result = res_q;

endmodule

### design/tngs_ctrl.sv
// tngs_ctrl: controller state machine sequencing read, evaluate and write-back
// depends on tngs_pkg

module tngs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tngs_pkg::dp_sts_t  sts,
	output tngs_pkg::ctl_cmd_t cmd,
	output logic               busy,
	output logic               done
);

	import tngs_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_WRITE = 3'd3;
	localparam logic [2:0] S_MISS  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (sts.in_range) begin
						state_d = S_READ;
					end else if (sts.in_take) begin
						cmd.clear_res = 1'b1;
						state_d       = S_MISS;
					end
					// an out-of-range insert is dropped here
				end
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_EVAL;
			end
			S_EVAL: begin
				if (!sts.op_take || sts.word_hit) begin
					cmd.eval_done = 1'b1;
					state_d       = S_WRITE;
				end else if (sts.next_any) begin
					// summary says that word is nonzero, so one hop suffices
					cmd.hop = 1'b1;
					state_d = S_READ;
				end else begin
					cmd.clear_res = 1'b1;
					state_d       = S_MISS;
				end
			end
			S_WRITE: begin
				cmd.mem_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_MISS: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = ((state_q == S_WRITE) && sts.op_take) || (state_q == S_MISS);

endmodule

### design/take_next_greater_from_set_unit.sv
// take_next_greater_from_set_unit: top level of the successor-with-removal set unit
// depends on tngs_pkg, tngs_ctrl, tngs_dp (and tngs_ram below it)
//
// Holds a set of values 1 .. MAX_VALUE-1 as a bitmap of 64-bit words in a ram,
// with a flip-flop summary that marks each nonzero word.
// Request channel: req is taken at a rising edge with start high and busy low.
//   req_type insert marks req.value present and gives no result; a zero or
//   out-of-range insert is dropped in the accept cycle.
//   req_type take finds the smallest present value above req.value, removes it
//   and returns it with found set; with none present, found 0 and value 0.
// Result channel: done is high for exactly one cycle with result valid; the
//   receiver cannot stall, so each result word must be taken in that cycle.
// Sequence: a take or insert whose value lies in the first bitmap word read
//   goes read, evaluate, write-back before the next accept; a take that must
//   move on to the next nonzero word reads and evaluates once more, due to the
//   single ram port and its registered read. A take that finds nothing after
//   its first read ends in a miss; a take at or above MAX_VALUE-1 misses at once.
// Reset: arst_n clears the summary, so the set starts empty at once; the ram
//   itself needs no clearing pass.

module take_next_greater_from_set_unit #(
	parameter int MAX_VALUE = tngs_pkg::MAX_VALUE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  tngs_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output tngs_pkg::res_t result
);

	import tngs_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	tngs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.sts   (sts),
		.cmd   (cmd),
		.busy  (busy),
		.done  (done)
	);

	tngs_dp #(
		.MAX_VALUE(MAX_VALUE)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.sts   (sts),
		.result(result)
	);

	// zero is never a member, so a found value is nonzero
	a_found_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!result.found || (result.taken_value != '0)))
		else $error("found result carries value zero");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.taken_value == '0))
		else $error("miss result carries nonzero value");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("unit still busy after result word");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result word outside a request");

endmodule

### tb/tb_take_next_greater_from_set_unit.sv
`timescale 1ns / 1ps
// tb_take_next_greater_from_set_unit: self-checking testbench for the take-next-greater set unit
// depends on tngs_pkg and take_next_greater_from_set_unit; a directed table, then random phases

module tb_take_next_greater_from_set_unit;
	import tngs_pkg::*;

	localparam int SET_SIZE   = MAX_VALUE_DEF;
	localparam bit FROM_MODEL = 1'b0;
	localparam bit FROM_TABLE = 1'b1;
	localparam int N_ROWS     = 25;

	typedef struct packed {
		logic             chk;
		logic             op;
		logic [VAL_W-1:0] arg;
		logic             hit;
		logic [VAL_W-1:0] hit_value;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	res_t result;

	// typed expectation that travels with the word on req
	logic     tag_table;
	res_t     tag_res;

	bit       present [0:SET_SIZE-1];
	res_t     expected_res [$];
	int       n_fail;
	int       burst_left;
	dir_row_t dir_rows [0:N_ROWS-1];

	take_next_greater_from_set_unit #(
		.MAX_VALUE(SET_SIZE)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	// insert marks a member; take removes the smallest member above the threshold
	task automatic set_update(input req_t r, output bit has_res, output res_t rr);
		int  v;
		bit  hit;
		hit     = 1'b0;
		rr      = '0;
		has_res = (r.req_type == REQ_TAKE);
		if (r.req_type == REQ_INSERT) begin
			if (r.value != '0) present[r.value] = 1'b1;
		end else begin
			for (v = int'(r.value) + 1; v < SET_SIZE && !hit; v++) begin
				if (present[v]) begin
					hit            = 1'b1;
					present[v]     = 1'b0;
					rr.found       = 1'b1;
					rr.taken_value = VAL_W'(v);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		bit   has_res;
		res_t rr;
		res_t want;
		if (arst_n && start && !busy) begin
			set_update(req, has_res, rr);
			if (has_res) expected_res.push_back(tag_table ? tag_res : rr);
		end
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				$error("result word with none expected: found %0d taken_value %0d",
					result.found, result.taken_value);
				n_fail++;
			end else begin
				want = expected_res.pop_front();
				if (result.found !== want.found) begin
					$error("found: expected %0d, got %0d", want.found, result.found);
					n_fail++;
				end
				if (result.taken_value !== want.taken_value) begin
					$error("taken_value: expected %0d, got %0d",
						want.taken_value, result.taken_value);
					n_fail++;
				end
			end
		end
	end

	// returns at the edge that accepts the word
	task automatic send_word(input req_t r, input logic chk, input res_t tab);
		req       <= r;
		tag_table <= chk;
		tag_res   <= tab;
		start     <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	// bursts of back-to-back words, random gaps with junk on req
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start        <= 1'b0;
			tag_table    <= FROM_MODEL;
			req.req_type <= 1'($urandom_range(0, 1));
			req.value    <= VAL_W'($urandom_range(0, (1 << VAL_W) - 1));
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (expected_res.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int n_words, input int ins_pct, input int lo,
		input int hi);
		req_t r;
		for (int i = 0; i < n_words; i++) begin
			r.req_type = ($urandom_range(0, 99) < ins_pct) ? REQ_INSERT : REQ_TAKE;
			if ($urandom_range(0, 9) == 0) r.value = VAL_W'($urandom_range(0, SET_SIZE - 1));
			else r.value = VAL_W'($urandom_range(lo, hi));
			send_word(r, FROM_MODEL, '0);
			pace();
		end
	endtask

	initial begin
		req_t r;
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		tag_table  = FROM_MODEL;
		tag_res    = '0;
		burst_left = 0;
		n_fail     = 0;

		dir_rows = '{
			'{FROM_TABLE, REQ_TAKE,   12'd0,    1'b0, 12'd0},    // empty set
			'{FROM_TABLE, REQ_TAKE,   12'd4095, 1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd0,    1'b0, 12'd0},    // zero is never a member
			'{FROM_TABLE, REQ_TAKE,   12'd0,    1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd4095, 1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd1,    1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd1,    1'b0, 12'd0},    // duplicate insert
			'{FROM_TABLE, REQ_TAKE,   12'd4094, 1'b1, 12'd4095},
			'{FROM_TABLE, REQ_TAKE,   12'd4095, 1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd4095, 1'b0, 12'd0},
			'{FROM_TABLE, REQ_TAKE,   12'd4095, 1'b0, 12'd0},    // threshold at the top
			'{FROM_TABLE, REQ_TAKE,   12'd0,    1'b1, 12'd1},
			'{FROM_TABLE, REQ_TAKE,   12'd0,    1'b1, 12'd4095},
			'{FROM_TABLE, REQ_TAKE,   12'd0,    1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd63,   1'b0, 12'd0},    // bitmap word edges
			'{FROM_MODEL, REQ_INSERT, 12'd64,   1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd128,  1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd2047, 1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd2730, 1'b0, 12'd0},
			'{FROM_MODEL, REQ_INSERT, 12'd1365, 1'b0, 12'd0},
			'{FROM_MODEL, REQ_TAKE,   12'd62,   1'b0, 12'd0},
			'{FROM_MODEL, REQ_TAKE,   12'd63,   1'b0, 12'd0},
			'{FROM_MODEL, REQ_TAKE,   12'd64,   1'b0, 12'd0},
			'{FROM_MODEL, REQ_TAKE,   12'd0,    1'b0, 12'd0},
			'{FROM_MODEL, REQ_TAKE,   12'd2047, 1'b0, 12'd0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			r.req_type = dir_rows[i].op;
			r.value    = dir_rows[i].arg;
			send_word(r, dir_rows[i].chk, '{dir_rows[i].hit, dir_rows[i].hit_value});
			pace();
		end
		drain();

		run_phase(300, 60, 0, SET_SIZE - 1);
		drain();
		run_phase(200, 55, SET_SIZE - 96, SET_SIZE - 1);   // crowd the top two words
		drain();
		run_phase(200, 25, 0, SET_SIZE - 1);               // sparse set, long scans, misses
		drain();
		run_phase(125, 50, 0, 200);                        // dense low words
		drain();

		repeat (16) @(posedge clk);
		if (n_fail == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
